// ===== sv/scl_pkg.sv =====
// ============================================================================
// Shell command line checker package
// Shared constants, codes and types for the command line checker.
// ============================================================================
package scl_pkg;

    localparam int MAX_STAGES    = 16;
    localparam int MAX_ARG_SLOTS = 64;

    localparam int STAGE_LOG = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int STAGE_W   = (STAGE_LOG > 4) ? STAGE_LOG : 4;
    localparam int SLOT_W    = $clog2(MAX_ARG_SLOTS + 1);
    localparam int ARG_W     = 6;
    localparam int ARG_LAST  = 63;

    localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(MAX_STAGES - 1);
    localparam logic [SLOT_W:0]    SLOT_LIMIT = (SLOT_W + 1)'(MAX_ARG_SLOTS);

    localparam logic [7:0] CH_EOL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LESS  = 8'h3c;
    localparam logic [7:0] CH_GREAT = 8'h3e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ARGS  = 3'd1;
    localparam logic [2:0] PH_AFTER = 3'd2;
    localparam logic [2:0] PH_NAME  = 3'd3;
    localparam logic [2:0] PH_AMP   = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;

    localparam logic [3:0] ROLE_SPACE = 4'd0;
    localparam logic [3:0] ROLE_ARG   = 4'd1;
    localparam logic [3:0] ROLE_IN    = 4'd2;
    localparam logic [3:0] ROLE_OUT   = 4'd3;
    localparam logic [3:0] ROLE_PIPE  = 4'd4;
    localparam logic [3:0] ROLE_AMP   = 4'd5;
    localparam logic [3:0] ROLE_LESS  = 4'd6;
    localparam logic [3:0] ROLE_GREAT = 4'd7;
    localparam logic [3:0] ROLE_IGN   = 4'd8;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_EMPTY    = 4'd1;
    localparam logic [3:0] ERR_AMP      = 4'd2;
    localparam logic [3:0] ERR_DUP_IN   = 4'd3;
    localparam logic [3:0] ERR_DUP_OUT  = 4'd4;
    localparam logic [3:0] ERR_BAD_NAME = 4'd5;
    localparam logic [3:0] ERR_NO_NAME  = 4'd6;
    localparam logic [3:0] ERR_AFTER    = 4'd7;
    localparam logic [3:0] ERR_STAGES   = 4'd8;
    localparam logic [3:0] ERR_ARGS     = 4'd9;

    typedef struct packed {
        logic eol;
        logic blank;
        logic special;
        logic pipe;
        logic amp;
        logic less;
        logic name_ok;
    } cls_t;

    typedef struct packed {
        logic [3:0]       role;
        logic             token_start;
        logic [3:0]       stage_index;
        logic [ARG_W-1:0] argument_index;
        logic             line_done;
        logic             line_ok;
        logic [3:0]       error_code;
        logic             background;
    } res_t;

endpackage

// ===== sv/scl_classify.sv =====
// ============================================================================
// Byte classifier
// Sorts one command line byte into end of line, blank, special or word
// and checks it against the legal filename set.
// ============================================================================
module scl_classify
    import scl_pkg::*;
(
    input  logic [7:0] ch,
    output cls_t       cls
);

    logic is_digit;
    logic is_upper;
    logic is_lower;
    logic is_punct;

    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_upper = (ch >= 8'h41) && (ch <= 8'h5a);
    assign is_lower = (ch >= 8'h61) && (ch <= 8'h7a);
    assign is_punct = (ch == CH_UNDER) || (ch == CH_DASH) || (ch == CH_DOT)
                   || (ch == CH_COMMA) || (ch == CH_SLASH) || (ch == CH_TILDE)
                   || (ch == CH_PLUS);

    always_comb
    begin
        cls.eol     = (ch == CH_EOL);
        cls.blank   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        cls.pipe    = (ch == CH_PIPE);
        cls.amp     = (ch == CH_AMP);
        cls.less    = (ch == CH_LESS);
        cls.special = cls.pipe || cls.amp || cls.less || (ch == CH_GREAT);
        cls.name_ok = is_digit || is_upper || is_lower || is_punct;
    end

endmodule

// ===== sv/scl_step.sv =====
// ============================================================================
// Line state and tagging
// Holds the parse state of the current line, tags each accepted byte
// and produces the verdict on the end of line byte.
// ============================================================================
module scl_step
    import scl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  cls_t cls,
    output res_t res
);

    logic [2:0]         phase_reg, phase_next;
    logic               tok_reg, tok_next;
    logic               redir_reg, redir_next;
    logic               in_seen_reg, in_seen_next;
    logic               out_seen_reg, out_seen_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ARG_W-1:0]   args_reg, args_next;
    logic [3:0]         err_reg, err_next;
    logic               bg_reg, bg_next;

    logic       fail;
    logic [3:0] fail_code;
    logic       take;
    logic [3:0] err_final;

    always_comb
    begin
        phase_next    = phase_reg;
        tok_next      = tok_reg;
        redir_next    = redir_reg;
        in_seen_next  = in_seen_reg;
        out_seen_next = out_seen_reg;
        stage_next    = stage_reg;
        slot_next     = slot_reg;
        args_next     = args_reg;
        err_next      = err_reg;
        bg_next       = bg_reg;

        fail      = 1'b0;
        fail_code = ERR_NONE;
        take      = 1'b0;
        err_final = ERR_NONE;

        res.role           = ROLE_IGN;
        res.token_start    = 1'b0;
        res.stage_index    = stage_reg[3:0];
        res.argument_index = '0;
        res.line_done      = 1'b0;
        res.line_ok        = 1'b0;
        res.error_code     = ERR_NONE;
        res.background     = 1'b0;

        priority if (cls.eol)
        begin
            res.line_done = 1'b1;
            if (phase_reg == PH_START)
            begin
                fail      = 1'b1;
                fail_code = ERR_EMPTY;
            end
            else if ((phase_reg == PH_NAME) && !tok_reg)
            begin
                fail      = 1'b1;
                fail_code = ERR_NO_NAME;
            end
            err_final = (err_reg != ERR_NONE) ? err_reg : fail_code;
            res.error_code = err_final;
            res.line_ok    = (err_final == ERR_NONE);
            res.background = (err_final == ERR_NONE)
                          && (bg_reg || (phase_reg == PH_AMP));
        end
        else if (phase_reg == PH_ERR)
        begin
            res.role = ROLE_IGN;
        end
        else if (cls.blank)
        begin
            res.role = ROLE_SPACE;
            if ((phase_reg == PH_NAME) && tok_reg)
            begin
                phase_next = PH_AFTER;
            end
            tok_next = 1'b0;
        end
        else if (cls.special)
        begin
            res.token_start = 1'b1;
            priority if (cls.pipe)
            begin
                res.role = ROLE_PIPE;
            end
            else if (cls.amp)
            begin
                res.role = ROLE_AMP;
            end
            else if (cls.less)
            begin
                res.role = ROLE_LESS;
            end
            else
            begin
                res.role = ROLE_GREAT;
            end
            tok_next = 1'b0;
            unique case (phase_reg)
                PH_START:
                begin
                    fail      = 1'b1;
                    fail_code = ERR_EMPTY;
                end
                PH_NAME:
                begin
                    if (!tok_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_NAME;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
                PH_ARGS:
                begin
                    slot_next = slot_reg + 1'b1;
                    take      = 1'b1;
                end
                PH_AFTER:
                begin
                    take = 1'b1;
                end
                default:
                begin
                    fail      = 1'b1;
                    fail_code = ERR_AMP;
                end
            endcase
            if (take)
            begin
                priority if (cls.pipe)
                begin
                    if (stage_reg == STAGE_LAST)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_STAGES;
                    end
                    else
                    begin
                        stage_next = stage_reg + 1'b1;
                        args_next  = '0;
                        phase_next = PH_START;
                    end
                end
                else if (cls.amp)
                begin
                    phase_next = PH_AMP;
                end
                else if (cls.less)
                begin
                    if (in_seen_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_DUP_IN;
                    end
                    else
                    begin
                        in_seen_next = 1'b1;
                        redir_next   = 1'b0;
                        phase_next   = PH_NAME;
                    end
                end
                else
                begin
                    if (out_seen_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_DUP_OUT;
                    end
                    else
                    begin
                        out_seen_next = 1'b1;
                        redir_next    = 1'b1;
                        phase_next    = PH_NAME;
                    end
                end
            end
        end
        else
        begin
            priority if ((phase_reg == PH_START) || (phase_reg == PH_ARGS))
            begin
                res.role = ROLE_ARG;
                if (tok_reg)
                begin
                    res.argument_index = args_reg - 1'b1;
                end
                else
                begin
                    res.token_start = 1'b1;
                    if ((args_reg >= ARG_W'(ARG_LAST))
                        || (({1'b0, slot_reg} + (SLOT_W + 1)'(2)) > SLOT_LIMIT))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_ARGS;
                    end
                    else
                    begin
                        res.argument_index = args_reg;
                        args_next  = args_reg + 1'b1;
                        slot_next  = slot_reg + 1'b1;
                        tok_next   = 1'b1;
                        phase_next = PH_ARGS;
                    end
                end
            end
            else if (phase_reg == PH_NAME)
            begin
                res.role        = redir_reg ? ROLE_OUT : ROLE_IN;
                res.token_start = !tok_reg;
                if (!cls.name_ok)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_NAME;
                end
                else
                begin
                    tok_next = 1'b1;
                end
            end
            else if (phase_reg == PH_AFTER)
            begin
                res.role        = ROLE_ARG;
                res.token_start = 1'b1;
                fail            = 1'b1;
                fail_code       = ERR_AFTER;
            end
            else
            begin
                res.role        = ROLE_ARG;
                res.token_start = 1'b1;
                fail            = 1'b1;
                fail_code       = ERR_AMP;
            end
        end

        if (fail)
        begin
            phase_next = PH_ERR;
            tok_next   = 1'b0;
            if (err_reg == ERR_NONE)
            begin
                err_next = fail_code;
            end
        end

        if (cls.eol)
        begin
            phase_next    = PH_START;
            tok_next      = 1'b0;
            redir_next    = 1'b0;
            in_seen_next  = 1'b0;
            out_seen_next = 1'b0;
            stage_next    = '0;
            slot_next     = '0;
            args_next     = '0;
            err_next      = ERR_NONE;
            bg_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            tok_reg      <= 1'b0;
            redir_reg    <= 1'b0;
            in_seen_reg  <= 1'b0;
            out_seen_reg <= 1'b0;
            stage_reg    <= '0;
            slot_reg     <= '0;
            args_reg     <= '0;
            err_reg      <= ERR_NONE;
            bg_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            tok_reg      <= tok_next;
            redir_reg    <= redir_next;
            in_seen_reg  <= in_seen_next;
            out_seen_reg <= out_seen_next;
            stage_reg    <= stage_next;
            slot_reg     <= slot_next;
            args_reg     <= args_next;
            err_reg      <= err_next;
            bg_reg       <= bg_next;
        end
    end

endmodule

// ===== sv/scl_outbuf.sv =====
// ============================================================================
// Result buffer
// Output register with a skid stage so the input side keeps moving
// while a result waits to be taken.
// ============================================================================
module scl_outbuf
    import scl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic full,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = out_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else
            begin
                if (pop)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else
        begin
            if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_reg <= push_res;
                end
                else
                begin
                    out_reg <= push_res;
                end
            end
        end
    end

endmodule

// ===== sv/shell_command_line_checker_core.sv =====
// ============================================================================
// Shell command line checker
// Tags each byte of a command line and reports the line verdict.
// ============================================================================
// One byte enters per cycle while ch_stall is low; each byte yields exactly
// one transaction on the result side via the output register. The parse
// state update is a single pass of logic, so bytes may follow back to back;
// a two-entry result buffer keeps ch_stall low until two results are waiting
// on a stalled output. A zero byte ends the line: its transaction carries
// line_done, line_ok, error_code and background, and the parse state returns
// to its reset value for the next line.
module shell_command_line_checker_core
    import scl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ch_valid,
    output logic             ch_stall,
    input  logic [7:0]       ch,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [3:0]       role,
    output logic             token_start,
    output logic [3:0]       stage_index,
    output logic [ARG_W-1:0] argument_index,
    output logic             line_done,
    output logic             line_ok,
    output logic [3:0]       error_code,
    output logic             background
);

    cls_t cls;
    res_t step_res;
    res_t buf_res;
    logic buf_full;
    logic accept;

    assign ch_stall = buf_full;
    assign accept   = ch_valid && !buf_full;

    scl_classify u_classify
    (
        .ch  (ch),
        .cls (cls)
    );

    scl_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .cls     (cls),
        .res     (step_res)
    );

    scl_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_res  (step_res),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (buf_res)
    );

    assign role           = buf_res.role;
    assign token_start    = buf_res.token_start;
    assign stage_index    = buf_res.stage_index;
    assign argument_index = buf_res.argument_index;
    assign line_done      = buf_res.line_done;
    assign line_ok        = buf_res.line_ok;
    assign error_code     = buf_res.error_code;
    assign background     = buf_res.background;

`ifndef SYNTHESIS
    a_done_tag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && line_done |-> (role == ROLE_IGN) && !token_start)
        else $error("end of line transaction carries a byte tag");

    a_err_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (error_code != ERR_NONE) |-> line_done && !line_ok)
        else $error("error code outside a failed verdict");

    a_bg_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (background || line_ok) |-> line_done && line_ok)
        else $error("background or ok flag outside an accepted verdict");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        ch_stall |-> res_valid)
        else $error("skid entry held while output register empty");
`endif

endmodule
